[hw/rtl/a85enc_pkg.sv]
// Shared types and constants of the ASCII85 stream encoder.
package a85enc_pkg;

    localparam int DIGITS      = 5;
    localparam int DIGIT_W     = 7;
    localparam int CHAR_W      = 7;
    localparam int VALUE_W     = 32;
    localparam int PROD_W      = 64;
    localparam int RECIP_SHIFT = 38;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    localparam logic [2:0]          GROUP_BYTES = 3'd4;
    localparam logic [2:0]          FIRST_DIV   = 3'd4;
    localparam logic [2:0]          LAST_DIV    = 3'd1;
    localparam logic [CHAR_W-1:0]   CHAR_OFFSET = 7'd33;
    localparam logic [VALUE_W-1:0]  BASE        = 32'd85;
    localparam logic [VALUE_W-1:0]  RECIP       = 32'd3233857729;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [2:0]         count;
        logic               last;
    } group_t;

    typedef struct packed {
        logic [DIGITS-1:0][DIGIT_W-1:0] digits;
        logic [2:0]                     count;
        logic                           last;
    } conv_res_t;

endpackage

[hw/rtl/a85enc_ifs.sv]
// Stream channel interfaces: raw bytes in, encoded characters out.
interface a85enc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface a85enc_char_if;
    logic                          valid;
    logic                          ready;
    logic [a85enc_pkg::CHAR_W-1:0] code_char;
    logic                          group_end;
    logic                          stream_end;

    modport source (output valid, output code_char, output group_end, output stream_end,
                    input ready);
    modport sink   (input valid, input code_char, input group_end, input stream_end,
                    output ready);
endinterface

[hw/rtl/a85enc_front.sv]
// Front end: gathers bytes into big-endian groups and pushes finished groups.
module a85enc_front (
    input  logic                clk,
    input  logic                rst_n,
    a85enc_byte_if.sink         byte_in,
    output logic                push_valid,
    input  logic                push_ready,
    output a85enc_pkg::group_t  push_data
);
    import a85enc_pkg::*;

    logic [23:0] group_value_reg, group_value_next;
    logic [1:0]  bytes_held_reg, bytes_held_next;
    logic [2:0]  count;
    logic [2:0]  pad;
    logic        finish;
    logic        accept;
    logic [31:0] joined;

    assign count  = {1'b0, bytes_held_reg} + 3'd1;
    assign pad    = GROUP_BYTES - count;
    assign finish = (count == GROUP_BYTES) || byte_in.last_byte;
    assign joined = {group_value_reg, byte_in.data_byte};

    assign byte_in.ready   = push_ready;
    assign push_valid      = byte_in.valid && finish;
    assign push_data.value = joined << {pad, 3'b000};
    assign push_data.count = count;
    assign push_data.last  = byte_in.last_byte;

    assign accept = byte_in.valid && byte_in.ready;

    always_comb
    begin
        group_value_next = group_value_reg;
        bytes_held_next  = bytes_held_reg;
        if (accept)
        begin
            if (finish)
            begin
                group_value_next = '0;
                bytes_held_next  = '0;
            end
            else
            begin
                group_value_next = {group_value_reg[15:0], byte_in.data_byte};
                bytes_held_next  = count[1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_value_reg <= '0;
            bytes_held_reg  <= '0;
        end
        else
        begin
            group_value_reg <= group_value_next;
            bytes_held_reg  <= bytes_held_next;
        end
    end

endmodule

[hw/rtl/a85enc_queue.sv]
// Two-entry group queue between the front end and the converter.
module a85enc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  a85enc_pkg::group_t  push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output a85enc_pkg::group_t  pop_data
);
    import a85enc_pkg::*;

    group_t     entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push;
    logic       pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

[hw/rtl/a85enc_conv.sv]
// Converter: splits a group value into five base-85 digits with a shared divide unit.
module a85enc_conv (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  a85enc_pkg::group_t     pop_data,
    output logic                   res_valid,
    input  logic                   res_ready,
    output a85enc_pkg::conv_res_t  res_data
);
    import a85enc_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_SUB, ST_DONE} state_t;

    state_t              state_reg, state_next;
    logic [VALUE_W-1:0]  v_reg, v_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [2:0]          idx_reg, idx_next;
    conv_res_t           res_reg, res_next;
    logic [QUOT_W-1:0]   quot;
    logic [VALUE_W-1:0]  back_mul;
    logic [VALUE_W-1:0]  rem;
    logic                load;

    assign quot      = prod_reg[PROD_W-1:RECIP_SHIFT];
    assign back_mul  = {{(VALUE_W-QUOT_W){1'b0}}, quot} * BASE;
    assign rem       = v_reg - back_mul;

    assign pop_ready = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && res_ready);
    assign load      = pop_valid && pop_ready;
    assign res_valid = (state_reg == ST_DONE);
    assign res_data  = res_reg;

    always_comb
    begin
        state_next = state_reg;
        v_next     = v_reg;
        prod_next  = prod_reg;
        idx_next   = idx_reg;
        res_next   = res_reg;
        unique case (state_reg)
            ST_IDLE, ST_DONE:
            begin
                if (state_reg == ST_DONE && res_ready)
                begin
                    state_next = ST_IDLE;
                end
                if (load)
                begin
                    v_next         = pop_data.value;
                    idx_next       = FIRST_DIV;
                    res_next.count = pop_data.count;
                    res_next.last  = pop_data.last;
                    state_next     = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = {{(PROD_W-VALUE_W){1'b0}}, v_reg} *
                             {{(PROD_W-VALUE_W){1'b0}}, RECIP};
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                res_next.digits[idx_reg] = rem[DIGIT_W-1:0];
                v_next = {{(VALUE_W-QUOT_W){1'b0}}, quot};
                if (idx_reg == LAST_DIV)
                begin
                    res_next.digits[0] = quot[DIGIT_W-1:0];
                    state_next         = ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg - 3'd1;
                    state_next = ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            v_reg     <= '0;
            prod_reg  <= '0;
            idx_reg   <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            v_reg     <= v_next;
            prod_reg  <= prod_next;
            idx_reg   <= idx_next;
            res_reg   <= res_next;
        end
    end

endmodule

[hw/rtl/a85enc_emit.sv]
// Emitter: sends count+1 characters of a converted group through an output register.
module a85enc_emit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   res_valid,
    output logic                   res_ready,
    input  a85enc_pkg::conv_res_t  res_data,
    a85enc_char_if.source          char_out
);
    import a85enc_pkg::*;

    conv_res_t          res_reg, res_next;
    logic               busy_reg, busy_next;
    logic [2:0]         k_reg, k_next;
    logic               valid_reg, valid_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               gend_reg, gend_next;
    logic               send_reg, send_next;
    logic               load_ok;
    logic               final_char;

    assign load_ok    = !valid_reg || char_out.ready;
    assign res_ready  = !busy_reg;
    assign final_char = (k_reg == res_reg.count);

    assign char_out.valid      = valid_reg;
    assign char_out.code_char  = char_reg;
    assign char_out.group_end  = gend_reg;
    assign char_out.stream_end = send_reg;

    always_comb
    begin
        res_next   = res_reg;
        busy_next  = busy_reg;
        k_next     = k_reg;
        valid_next = valid_reg && !char_out.ready;
        char_next  = char_reg;
        gend_next  = gend_reg;
        send_next  = send_reg;
        if (!busy_reg)
        begin
            if (res_valid)
            begin
                res_next  = res_data;
                k_next    = '0;
                busy_next = 1'b1;
            end
        end
        else if (load_ok)
        begin
            valid_next = 1'b1;
            char_next  = res_reg.digits[k_reg] + CHAR_OFFSET;
            gend_next  = final_char;
            send_next  = final_char && res_reg.last;
            k_next     = k_reg + 3'd1;
            if (final_char)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg   <= '0;
            busy_reg  <= 1'b0;
            k_reg     <= '0;
            valid_reg <= 1'b0;
            char_reg  <= '0;
            gend_reg  <= 1'b0;
            send_reg  <= 1'b0;
        end
        else
        begin
            res_reg   <= res_next;
            busy_reg  <= busy_next;
            k_reg     <= k_next;
            valid_reg <= valid_next;
            char_reg  <= char_next;
            gend_reg  <= gend_next;
            send_reg  <= send_next;
        end
    end

endmodule

[hw/rtl/ascii85_stream_encoder_unit.sv]
// ASCII85 stream encoder: byte stream in, base-85 character stream out.
//
// byte_in carries one raw byte per word with last_byte marking the end of a
// stream; char_out carries one character per word with group_end on the final
// character of each group and stream_end on the final character of a stream.
// Bytes are gathered into 4-byte groups; a full group gives 5 characters and a
// short final group of c bytes gives c+1 characters.
// A finished group passes through the queue, the converter and the emitter's
// output register before its first character appears. The group rate is set by
// the converter's shared divide-by-85 unit, which takes one group at a time (a
// multiply and a remainder step per digit, four digits, plus the hand-off).
// A two-entry queue lets the front end keep taking bytes while the converter
// is busy, and the output register lets the emitter hold a character while
// the converter works on the next group.
// A stall on char_out holds the current character and backs up through the
// emitter, converter and queue to byte_in.ready.
// Reset clears the partial group, the queue and all valid flags.
module ascii85_stream_encoder_unit (
    input  logic           clk,
    input  logic           rst_n,
    a85enc_byte_if.sink    byte_in,
    a85enc_char_if.source  char_out
);
    import a85enc_pkg::*;

    logic       push_valid;
    logic       push_ready;
    group_t     push_data;
    logic       pop_valid;
    logic       pop_ready;
    group_t     pop_data;
    logic       res_valid;
    logic       res_ready;
    conv_res_t  res_data;

    a85enc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    a85enc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    a85enc_conv u_conv (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

    a85enc_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data),
        .char_out   (char_out)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        char_out.valid && char_out.stream_end |-> char_out.group_end)
        else $error("stream end without group end");

    assert property (@(posedge clk) disable iff (!rst_n)
        char_out.valid |-> (char_out.code_char >= 7'd33) && (char_out.code_char <= 7'd117))
        else $error("character outside the base-85 range");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.count != 3'd0) && (res_data.count <= GROUP_BYTES))
        else $error("converted group with a bad byte count");

endmodule
